FILE: design/mowm_pkg.sv
// mowm_pkg: shared constants and controller/datapath command and status structs
// no dependencies
`default_nettype none
package mowm_pkg;
   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int VAL_W     = 32;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SORT_CLR,
      OP_SORT_CMP,
      OP_RUN
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   i;
      logic [IDX_W-1:0]   j;
      logic [CNT_W-1:0]   n;
   } cmd_type;

   // best run after the rank step last addressed, registered from that address
   typedef struct packed {
      logic [CNT_W-1:0]   run;
   } stat_type;
endpackage
`default_nettype wire

FILE: design/mowm_datapath.sv
// mowm_datapath: value store, ranking, active runs and per-rank results
// depends on mowm_pkg
`default_nettype none
module mowm_datapath (
   input  wire logic                              clock,
   input  wire mowm_pkg::cmd_type                 cmd,
   input  wire logic [mowm_pkg::VAL_W-1:0]        load_value,
   output mowm_pkg::stat_type                     stat,
   output logic [mowm_pkg::VAL_W-1:0]             best_value
);
   // value store, rank to position, rank to value, run ends, best run per rank
   logic [mowm_pkg::VAL_W-1:0] vals_ff [mowm_pkg::MAX_ITEMS];
   logic [mowm_pkg::IDX_W-1:0] spos_ff [mowm_pkg::MAX_ITEMS];
   logic [mowm_pkg::VAL_W-1:0] sval_ff [mowm_pkg::MAX_ITEMS];
   logic [mowm_pkg::CNT_W-1:0] best_ff [mowm_pkg::MAX_ITEMS];
   logic [mowm_pkg::CNT_W-1:0] lrun_ff [mowm_pkg::MAX_ITEMS];
   logic [mowm_pkg::CNT_W-1:0] rrun_ff [mowm_pkg::MAX_ITEMS];
   logic [mowm_pkg::CNT_W-1:0] bestrun_ff;
   logic [mowm_pkg::VAL_W-1:0] vi_ff, vj_ff;
   logic [mowm_pkg::IDX_W-1:0] pos_ff;
   logic [mowm_pkg::IDX_W-1:0] rank_ff;
   logic [mowm_pkg::CNT_W-1:0] lft_ff, rgt_ff;
   logic [mowm_pkg::CNT_W-1:0] run_rd_ff;
   logic [mowm_pkg::VAL_W-1:0] sval_rd_ff;
   mowm_pkg::cmd_type          cmd_d_ff;
   logic                       beat;
   logic                       last_cmp;
   logic [mowm_pkg::IDX_W-1:0] rank_base, rank_sum;
   logic [mowm_pkg::CNT_W-1:0] tot, new_best;
   logic [mowm_pkg::IDX_W-1:0] lo, hi;

   assign stat.run   = run_rd_ff;
   assign best_value = sval_rd_ff;

   // compare stage works on the values registered from the previous command
   // position j ranks before i if greater, or equal and earlier (stable)
   always_comb begin
      beat      = (vj_ff > vi_ff) || ((vj_ff == vi_ff) && (cmd_d_ff.j < cmd_d_ff.i));
      rank_base = (cmd_d_ff.j == '0) ? '0 : rank_ff;
      rank_sum  = rank_base + mowm_pkg::IDX_W'(beat);
      last_cmp  = (cmd_d_ff.op == mowm_pkg::OP_SORT_CMP) &&
                  ({1'b0, cmd_d_ff.j} == cmd_d_ff.n - 1'b1);
   end

   // joining a new position with the runs that end next to it
   always_comb begin
      tot      = lft_ff + rgt_ff + 1'b1;
      lo       = pos_ff - lft_ff[mowm_pkg::IDX_W-1:0];
      hi       = pos_ff + rgt_ff[mowm_pkg::IDX_W-1:0];
      new_best = (tot > bestrun_ff) ? tot : bestrun_ff;
   end

   always_ff @(posedge clock) begin
      cmd_d_ff   <= cmd;
      vi_ff      <= vals_ff[cmd.i];
      vj_ff      <= vals_ff[cmd.j];
      pos_ff     <= spos_ff[cmd.i];
      sval_rd_ff <= sval_ff[cmd.i];
      run_rd_ff  <= best_ff[cmd.i];
      // lrun is valid at the right end of a run, rrun at its left end
      if (pos_ff != '0) lft_ff <= lrun_ff[pos_ff - 1'b1];
      else lft_ff <= '0;
      if ({1'b0, pos_ff} + 1'b1 < cmd.n) rgt_ff <= rrun_ff[pos_ff + 1'b1];
      else rgt_ff <= '0;
      case (cmd.op)
         mowm_pkg::OP_LOAD: vals_ff[cmd.i] <= load_value;
         mowm_pkg::OP_SORT_CLR: begin
            lrun_ff[cmd.i] <= '0;
            rrun_ff[cmd.i] <= '0;
            bestrun_ff     <= '0;
         end
         mowm_pkg::OP_RUN: begin
            // i is the rank step; pos_ff holds the position at that rank
            lrun_ff[hi]    <= tot;
            rrun_ff[lo]    <= tot;
            bestrun_ff     <= new_best;
            best_ff[cmd.i] <= new_best;
         end
         default: ;
      endcase
      // rank of position i counts every j that beats it
      if (cmd_d_ff.op == mowm_pkg::OP_SORT_CMP)
         rank_ff <= rank_sum;
      if (last_cmp) begin
         spos_ff[rank_sum] <= cmd_d_ff.i;
         sval_ff[rank_sum] <= vi_ff;
      end
   end
endmodule
`default_nettype wire

FILE: design/max_of_window_minimums.sv
// max_of_window_minimums: top level, controller plus datapath
// depends on mowm_pkg, mowm_datapath
//
//  channel | ports                                          | handshake
//  req     | req_value, req_last                            | req_valid / req_ready
//  rsp     | rsp_window_size, rsp_best_min, rsp_last_result | rsp_valid / rsp_ready
//
// loading takes items back to back; after the last item of n come a clear pass,
// n*n ranking compares (one per cycle), a drain step and the run steps for each rank
// each result then takes a read and a test for each rank tested, then the output
// register; the scan resumes where it stopped, so at most 2n-1 rank tests in all
// reset is synchronous and active high; no clearing pass is needed
// a stalled result holds the scan; no item is taken until all results leave
`default_nettype none
module max_of_window_minimums (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_value,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_window_size,
   output logic [31:0]      rsp_best_min,
   output logic             rsp_last_result
);
   typedef enum logic [3:0] {
      S_LOAD, S_CLR, S_CMP, S_DRAIN, S_RUNA, S_RUNB, S_RUNC, S_KA, S_KB, S_OUT
   } state_type;

   state_type state_ff;
   logic [mowm_pkg::IDX_W-1:0] i_ff, j_ff;
   logic [mowm_pkg::CNT_W-1:0] n_ff, k_ff;
   mowm_pkg::cmd_type  cmd;
   mowm_pkg::stat_type stat;
   logic [31:0] best_value;
   logic last_in;

   assign req_ready = (state_ff == S_LOAD);
   // the item that fills the store ends the sequence whatever its flag says
   assign last_in = req_last || (n_ff == mowm_pkg::CNT_W'(mowm_pkg::MAX_ITEMS - 1));

   always_comb begin
      cmd.i = i_ff;
      cmd.j = j_ff;
      cmd.n = n_ff;
      case (state_ff)
         S_LOAD: begin
            cmd.op = (req_valid) ? mowm_pkg::OP_LOAD : mowm_pkg::OP_IDLE;
            cmd.i  = n_ff[mowm_pkg::IDX_W-1:0];
         end
         S_CLR:  cmd.op = mowm_pkg::OP_SORT_CLR;
         S_CMP:  cmd.op = mowm_pkg::OP_SORT_CMP;
         S_RUNC: cmd.op = mowm_pkg::OP_RUN;
         default: cmd.op = mowm_pkg::OP_IDLE;
      endcase
   end

   mowm_datapath u_dp (
      .clock(clock), .cmd(cmd), .load_value(req_value),
      .stat(stat), .best_value(best_value)
   );

   // controller
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         n_ff      <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         rsp_valid <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: if (req_valid) begin
               n_ff <= n_ff + 1'b1;
               if (last_in) begin
                  state_ff <= S_CLR;
                  i_ff <= '0;
               end
            end
            S_CLR: begin
               if ({1'b0, i_ff} == n_ff - 1'b1) begin
                  i_ff <= '0; j_ff <= '0; state_ff <= S_CMP;
               end else i_ff <= i_ff + 1'b1;
            end
            S_CMP: begin
               // values are registered ahead of the compare
               if ({1'b0, j_ff} == n_ff - 1'b1) begin
                  j_ff <= '0;
                  if ({1'b0, i_ff} == n_ff - 1'b1) begin
                     i_ff <= '0; state_ff <= S_DRAIN;
                  end else i_ff <= i_ff + 1'b1;
               end else j_ff <= j_ff + 1'b1;
            end
            // last compare writes its rank before the first position read
            S_DRAIN: state_ff <= S_RUNA;
            // position read, neighbor run read, join and record
            S_RUNA: state_ff <= S_RUNB;
            S_RUNB: state_ff <= S_RUNC;
            S_RUNC: begin
               if ({1'b0, i_ff} == n_ff - 1'b1) begin
                  i_ff <= '0; k_ff <= mowm_pkg::CNT_W'(1); state_ff <= S_KA;
               end else begin
                  i_ff <= i_ff + 1'b1; state_ff <= S_RUNA;
               end
            end
            // best run at rank i is read here, tested in S_KB
            S_KA: state_ff <= S_KB;
            S_KB: begin
               if (stat.run >= k_ff || {1'b0, i_ff} == n_ff - 1'b1) begin
                  rsp_valid       <= 1'b1;
                  rsp_window_size <= k_ff;
                  rsp_best_min    <= best_value;
                  rsp_last_result <= (k_ff == n_ff);
                  state_ff        <= S_OUT;
               end else begin
                  i_ff <= i_ff + 1'b1; state_ff <= S_KA;
               end
            end
            S_OUT: if (rsp_ready) begin
               rsp_valid <= 1'b0;
               if (k_ff == n_ff) begin
                  n_ff <= '0; i_ff <= '0; state_ff <= S_LOAD;
               end else begin
                  k_ff <= k_ff + 1'b1; state_ff <= S_KA;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken during output");
   a_size_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_size != 0 && rsp_window_size <= n_ff))
      else $error("window size out of range");
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_result) |=> req_ready)
      else $error("no return to load");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_best_min) &&
                                     $stable(rsp_window_size)))
      else $error("result dropped or changed while stalled");
`endif
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// testbench: drives value sequences into max_of_window_minimums and checks every result
// depends on max_of_window_minimums and mowm_pkg (MAX_ITEMS)
`default_nettype none
module testbench;
   typedef struct {
      logic [31:0] value;
      logic        last;
   } seq_item_type;

   typedef struct {
      logic [6:0]  window_size;
      logic [31:0] best_min;
      logic        last_result;
   } window_answer_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_value;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [6:0]  rsp_window_size;
   logic [31:0] rsp_best_min;
   logic        rsp_last_result;

   seq_item_type      pending_items[$];
   window_answer_type expected_answers[$];
   logic [31:0]       seq_values[$];
   int                errors;
   int                cycle_count;
   int                burst_left;
   int                gap_left;
   bit                stim_done;

   max_of_window_minimums dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_window_size(rsp_window_size), .rsp_best_min(rsp_best_min),
      .rsp_last_result(rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // answers for one whole sequence: for each k, the largest v with a run of
   // length k all >= v; brute force over windows, independent of the block's method
   task automatic compute_window_answers();
      int n;
      logic [31:0] best, wmin;
      window_answer_type a;
      n = seq_values.size();
      for (int k = 1; k <= n; k++) begin
         best = 32'd0;
         for (int s = 0; s + k <= n; s++) begin
            wmin = seq_values[s];
            for (int t = s; t < s + k; t++)
               if (seq_values[t] < wmin) wmin = seq_values[t];
            if (wmin > best) best = wmin;
         end
         a.window_size = k[6:0];
         a.best_min    = best;
         a.last_result = (k == n);
         expected_answers = {expected_answers, a};
      end
      seq_values.delete();
   endtask

   // queue a sequence; the MAX_ITEMS-th item ends it whatever its flag says
   task automatic queue_sequence(input logic [31:0] vals[$], input bit set_last);
      seq_item_type it;
      foreach (vals[i]) begin
         it.value = vals[i];
         it.last  = (i == vals.size() - 1) ? set_last : 1'b0;
         pending_items = {pending_items, it};
      end
   endtask

   function automatic logic [31:0] rand_value(input int mode);
      case (mode)
         0: rand_value = $urandom;
         1: rand_value = $urandom_range(0, 7);
         2: rand_value = 32'hFFFF_FFF8 | $urandom_range(0, 7);
         default: rand_value = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd0;
      endcase
   endfunction

   // stimulus: directed sequences first, then random ones
   initial begin
      logic [31:0] v[$];
      int len, mode;
      // single element, extremes
      v = '{32'd0}; queue_sequence(v, 1'b1);
      v = '{32'hFFFF_FFFF}; queue_sequence(v, 1'b1);
      // ties, ascending, descending, valley
      v = '{32'd5, 32'd5, 32'd5}; queue_sequence(v, 1'b1);
      v = '{32'd1, 32'd2, 32'd3, 32'd4}; queue_sequence(v, 1'b1);
      v = '{32'hFFFF_FFFF, 32'h8000_0000, 32'd0}; queue_sequence(v, 1'b1);
      v = '{32'd9, 32'd0, 32'd9, 32'hAAAA_5555, 32'h5555_AAAA}; queue_sequence(v, 1'b1);
      // full-length sequence, forced end at the store size with last low
      v.delete();
      for (int i = 0; i < mowm_pkg::MAX_ITEMS; i++) v = {v, rand_value(i % 4)};
      queue_sequence(v, 1'b0);
      while (pending_items.size() < 260) begin
         v.delete();
         mode = $urandom_range(0, 3);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, mowm_pkg::MAX_ITEMS)
                                           : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) v = {v, rand_value(mode)};
         queue_sequence(v, len == mowm_pkg::MAX_ITEMS ? $urandom_range(0, 1) : 1'b1);
      end
   end

   // driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_value  <= 32'd0;
         req_last   <= 1'b0;
         burst_left <= $urandom_range(1, 20);
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            seq_values = {seq_values, req_value};
            if (req_last || seq_values.size() == mowm_pkg::MAX_ITEMS)
               compute_window_answers();
         end
         if (req_valid && !req_ready) begin
            // hold the item until it is taken
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_items.size() > 0) begin
            req_valid <= 1'b1;
            req_value <= pending_items[0].value;
            req_last  <= pending_items[0].last;
            void'(pending_items.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left   <= $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // monitor: compare each result with the oldest expected answer
   always @(posedge clock) begin
      window_answer_type exp_a;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         // receiver stall pattern: long free stretches, then random stalls
         rsp_ready <= ((cycle_count / 500) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected result k=%0d min=%0h", $time,
                        rsp_window_size, rsp_best_min);
               errors++;
            end else begin
               exp_a = expected_answers.pop_front();
               if (rsp_window_size !== exp_a.window_size) begin
                  $display("%0t: window_size expected %0d actual %0d", $time,
                           exp_a.window_size, rsp_window_size);
                  errors++;
               end
               if (rsp_best_min !== exp_a.best_min) begin
                  $display("%0t: best_min k=%0d expected %0h actual %0h", $time,
                           exp_a.window_size, exp_a.best_min, rsp_best_min);
                  errors++;
               end
               if (rsp_last_result !== exp_a.last_result) begin
                  $display("%0t: last_result k=%0d expected %0b actual %0b", $time,
                           exp_a.window_size, exp_a.last_result, rsp_last_result);
                  errors++;
               end
            end
         end
      end
   end

   // reset, end of run and cycle limit
   initial begin
      cycle_count = 0;
      reset       = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stim_done && !req_valid && expected_answers.size() == 0);
            repeat (200) @(posedge clock);
            if (errors == 0 && expected_answers.size() == 0)
               $display("testbench OK");
            else
               $display("testbench NOT OK");
            $finish;
         end
         begin
            while (cycle_count < 1000000) begin
               @(posedge clock);
               cycle_count++;
            end
            $display("testbench NOT OK");
            $finish;
         end
      join
   end
endmodule
`default_nettype wire
